/* hw/rtl/ipv6tap_pkg.sv */
// Package for the IPv6 text address parser: widths, character codes and the
// hex digit decoder. No dependencies.
package ipv6tap_pkg;

    localparam int CHAR_W      = 8;
    localparam int GROUP_W     = 16;
    localparam int NUM_GROUPS  = 8;
    localparam int ADDR_W      = GROUP_W * NUM_GROUPS;
    localparam int HALF_W      = ADDR_W / 2;
    localparam int DIGIT_W     = 3;
    localparam int COUNT_W     = 4;
    localparam int POS_W       = 2;
    localparam int RES_W       = 1 + ADDR_W;
    localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F_UP  = 8'h46;

    localparam logic [DIGIT_W-1:0] MAX_DIGITS = 3'd4;
    localparam logic [POS_W-1:0]   POS_SAT    = 2'd3;
    localparam logic [COUNT_W-1:0] GROUPS_MAX = 4'd8;
    localparam logic [COUNT_W-1:0] GAP_MAX    = 4'd7;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_digit_t       d;
        logic [CHAR_W-1:0] v;
        d = '0;
        v = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = c - CHAR_0;
            d.is_hex = 1'b1;
        end else if (c >= CHAR_A_LO && c <= CHAR_F_LO) begin
            v = c - CHAR_A_LO + 8'd10;
            d.is_hex = 1'b1;
        end else if (c >= CHAR_A_UP && c <= CHAR_F_UP) begin
            v = c - CHAR_A_UP + 8'd10;
            d.is_hex = 1'b1;
        end
        d.value = v[3:0];
        return d;
    endfunction

endpackage

/* hw/rtl/ipv6_text_address_parser.sv */
// The last character is registered in the input stage, then its result in the output register.
// Throughput: one character per cycle; the input stalls only while a finished result
// waits in the output register and the next pending item is itself a last character.
// Reset (rst_n low, asynchronous) clears all parse flags, counters and valid bits;
// the group shift registers are not reset.
// Depends on ipv6tap_pkg.
module ipv6_text_address_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ipv6tap_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] char_code
    input  logic                               s_tlast,   // last_char
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ipv6tap_pkg::M_TDATA_W-1:0]  m_tdata    // [0] valid_res, [64:1] addr_high,
                                                          // [128:65] addr_low, rest zero
);
    import ipv6tap_pkg::*;

    logic                 s1_valid_reg;
    logic [CHAR_W-1:0]    s1_char_reg;
    logic                 s1_last_reg;
    logic                 advance;

    logic [ADDR_W-1:0]    front_vec_reg, front_vec_next;
    logic [ADDR_W-1:0]    rear_vec_reg,  rear_vec_next;
    logic [COUNT_W-1:0]   front_count_reg, front_count_next;
    logic [COUNT_W-1:0]   rear_count_reg,  rear_count_next;
    logic                 gap_seen_reg,    gap_seen_next;
    logic [GROUP_W-1:0]   group_value_reg, group_value_next;
    logic [DIGIT_W-1:0]   digit_count_reg, digit_count_next;
    logic                 colon_pending_reg, colon_pending_next;
    logic [POS_W-1:0]     char_position_reg, char_position_next;
    logic                 failed_reg,      failed_next;
    logic                 ended_reg,       ended_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    hex_digit_t           hex;
    logic                 a_commit;
    logic                 commit_req;
    logic [COUNT_W-1:0]   total;
    logic [COUNT_W-1:0]   fin_total;
    logic                 ok;
    logic [COUNT_W-1:0]   front_gap;
    logic [COUNT_W-1:0]   rear_gap;
    logic [ADDR_W-1:0]    front_placed;
    logic [ADDR_W-1:0]    rear_mask;
    logic [ADDR_W-1:0]    addr;

    assign advance  = s1_valid_reg && (!s1_last_reg || !m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // character step, then group commit, then verdict and address packing
    always_comb
    begin
        hex                = hex_decode(s1_char_reg);
        a_commit           = 1'b0;
        front_vec_next     = front_vec_reg;
        rear_vec_next      = rear_vec_reg;
        front_count_next   = front_count_reg;
        rear_count_next    = rear_count_reg;
        gap_seen_next      = gap_seen_reg;
        group_value_next   = group_value_reg;
        digit_count_next   = digit_count_reg;
        colon_pending_next = colon_pending_reg;
        char_position_next = char_position_reg;
        failed_next        = failed_reg;
        ended_next         = ended_reg;

        if (!ended_reg && !failed_reg) begin
            if (s1_char_reg == CHAR_NUL) begin
                ended_next = 1'b1;
            end else begin
                if (hex.is_hex) begin
                    if (digit_count_reg >= MAX_DIGITS
                        || (colon_pending_reg && char_position_reg == 2'd1)) begin
                        failed_next = 1'b1;
                    end else begin
                        group_value_next = {group_value_reg[GROUP_W-5:0], hex.value};
                        digit_count_next = digit_count_reg + 3'd1;
                    end
                    colon_pending_next = 1'b0;
                end else if (s1_char_reg == CHAR_COLON) begin
                    if (colon_pending_reg) begin
                        if (gap_seen_reg) begin
                            failed_next = 1'b1;
                        end
                        gap_seen_next      = 1'b1;
                        colon_pending_next = 1'b0;
                    end else if (digit_count_reg == '0) begin
                        if (char_position_reg == '0) begin
                            colon_pending_next = 1'b1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end else begin
                        a_commit           = 1'b1;
                        colon_pending_next = 1'b1;
                    end
                end else begin
                    failed_next = 1'b1;
                end
                if (char_position_reg != POS_SAT) begin
                    char_position_next = char_position_reg + 2'd1;
                end
            end
        end else if (s1_char_reg == CHAR_NUL) begin
            ended_next = 1'b1;
        end

        // at most one group commit per character
        commit_req = !failed_next && (a_commit || (s1_last_reg && digit_count_next != '0));
        total      = front_count_next + rear_count_next;
        if (commit_req) begin
            if (total >= GROUPS_MAX) begin
                failed_next = 1'b1;
            end else begin
                if (gap_seen_next) begin
                    rear_vec_next   = {rear_vec_reg[ADDR_W-GROUP_W-1:0], group_value_next};
                    rear_count_next = rear_count_next + 4'd1;
                end else begin
                    front_vec_next   = {front_vec_reg[ADDR_W-GROUP_W-1:0], group_value_next};
                    front_count_next = front_count_next + 4'd1;
                end
                group_value_next = '0;
                digit_count_next = '0;
            end
        end

        fin_total = front_count_next + rear_count_next;
        ok        = !failed_next && !colon_pending_next
                    && (gap_seen_next ? (fin_total <= GAP_MAX) : (fin_total == GROUPS_MAX));

        // front groups go to the top, rear groups stay at the bottom, zeros between
        front_gap    = GROUPS_MAX - front_count_next;
        rear_gap     = GROUPS_MAX - rear_count_next;
        front_placed = front_vec_next << {front_gap, 4'b0000};
        rear_mask    = {ADDR_W{1'b1}} >> {rear_gap, 4'b0000};
        addr         = ok ? (front_placed | (rear_vec_next & rear_mask)) : '0;

        m_tdata_next = '0;
        m_tdata_next[0]                   = ok;
        m_tdata_next[HALF_W:1]            = addr[ADDR_W-1:HALF_W];
        m_tdata_next[ADDR_W:HALF_W+1]     = addr[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (advance) begin
            front_vec_reg <= front_vec_next;
            rear_vec_reg  <= rear_vec_next;
        end
        if (advance && s1_last_reg) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            front_count_reg   <= '0;
            rear_count_reg    <= '0;
            gap_seen_reg      <= 1'b0;
            group_value_reg   <= '0;
            digit_count_reg   <= '0;
            colon_pending_reg <= 1'b0;
            char_position_reg <= '0;
            failed_reg        <= 1'b0;
            ended_reg         <= 1'b0;
        end else if (advance) begin
            if (s1_last_reg) begin
                front_count_reg   <= '0;
                rear_count_reg    <= '0;
                gap_seen_reg      <= 1'b0;
                group_value_reg   <= '0;
                digit_count_reg   <= '0;
                colon_pending_reg <= 1'b0;
                char_position_reg <= '0;
                failed_reg        <= 1'b0;
                ended_reg         <= 1'b0;
            end else begin
                front_count_reg   <= front_count_next;
                rear_count_reg    <= rear_count_next;
                gap_seen_reg      <= gap_seen_next;
                group_value_reg   <= group_value_next;
                digit_count_reg   <= digit_count_next;
                colon_pending_reg <= colon_pending_next;
                char_position_reg <= char_position_next;
                failed_reg        <= failed_next;
                ended_reg         <= ended_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance && s1_last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/ipv6tap_checker.sv */
// Port-level checks for the IPv6 text address parser, bound to the top level.
// Depends on ipv6tap_pkg and ipv6_text_address_parser.
module ipv6tap_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ipv6tap_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ipv6tap_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the input only stalls behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a rejected address carries an all-zero address
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[ADDR_W:1] == '0)
        else $error("invalid verdict with nonzero address");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:RES_W] == '0)
        else $error("nonzero padding in result");

endmodule

bind ipv6_text_address_parser ipv6tap_checker u_ipv6tap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
